### hw/rtl/ppst_pkg.sv
// shared constants, types and codes of the packed pixel store
`timescale 1ns / 1ps
`default_nettype none
package ppst_pkg;

    localparam int STORE_BYTES = 65536;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int CNT_W       = ADDR_W + 1;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 16;
    localparam int MUL_B_W = 13;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;

    localparam logic [5:0] BPP_MAX  = 6'd32;
    localparam logic [7:0] BYTE_ALL = 8'hFF;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLIP  = 2'd2,
        OP_CHECK = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_BPP    = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage
`default_nettype wire

### hw/rtl/ppst_mul.sv
// shared multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module ppst_mul (
    input  wire logic                          i_clk,
    input  wire logic [ppst_pkg::MUL_A_W-1:0] i_a,
    input  wire logic [ppst_pkg::MUL_B_W-1:0] i_b,
    output logic      [ppst_pkg::PROD_W-1:0]  o_p
);

    logic [ppst_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= ppst_pkg::PROD_W'(i_a) * ppst_pkg::PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

### hw/rtl/ppst_mem.sv
// byte-wide pixel memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module ppst_mem (
    input  wire logic               i_clk,
    input  wire ppst_pkg::t_mem_req i_req,
    output logic [7:0]              o_rdata
);

    logic [7:0] r_mem [ppst_pkg::STORE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hw/rtl/packed_pixel_store.sv
// packed pixel store: sequencer around a byte memory and a shared multiplier
`timescale 1ns / 1ps
`default_nettype none
// One transaction in, one result out, one item at a time. After reset the block
// clears its 65536-byte memory one byte per cycle and takes no item until the
// clearing pass is done (configuration writes are taken throughout). Every item
// first works out the row stride and used area on the shared multiplier. An
// item with a depth of 0 or above 32 skips this and is refused. A pixel read
// then reads each byte the pixel touches in turn, up to five for an odd depth,
// and a pixel write does a read-modify-write of each such byte over the
// memory's one read and one write port. Row flip reads and writes back each
// swapped byte pair in turn, the opaque check reads each used byte, stopping at
// the first byte that is not 0xFF. A finished result sits in an output
// register, so the next item may enter while it waits to be taken.
module packed_pixel_store (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: 0 pixel depth, 1 width_pixels, 2 height_rows
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // op[1:0], row[13:2], col[25:14], pixel_in[57:26], zero pad
    input  wire logic [ppst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pixel_out[31:0], all_opaque[32], status[33], zero pad
    output logic [ppst_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int ADDR_W = ppst_pkg::ADDR_W;
    localparam int CNT_W  = ppst_pkg::CNT_W;
    localparam int PROD_W = ppst_pkg::PROD_W;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_STRIDE,
        S_USED,
        S_CHECK,
        S_PIX1,
        S_PIX2,
        S_RD,
        S_RDW,
        S_PIXOUT,
        S_FRA,
        S_FRB,
        S_FWA,
        S_FWB,
        S_ORD,
        S_OCMP,
        S_RES
    } t_state;

    t_state r_state;

    logic [5:0]  r_bpp;
    logic [12:0] r_width;
    logic [12:0] r_height;

    ppst_pkg::t_op r_op;
    logic [11:0]   r_row;
    logic [11:0]   r_col;
    logic [31:0]   r_pix;

    logic [15:0]       r_stride;
    logic [17:0]       r_bitpos;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_addr_b;
    logic [CNT_W-1:0]  r_cnt;
    logic [11:0]       r_pairs;
    logic [39:0]       r_acc;
    logic [39:0]       r_mask;
    logic [39:0]       r_val;
    logic [5:0]        r_shift;
    logic [7:0]        r_tmp;

    logic [31:0] r_pixel;
    logic        r_opaque;
    logic        r_status;

    logic        r_ovalid;
    logic [31:0] r_opixel;
    logic        r_oopaque;
    logic        r_ostatus;

    logic [ppst_pkg::MUL_A_W-1:0] mul_a;
    logic [ppst_pkg::MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]            prod;

    ppst_pkg::t_mem_req mem_req;
    logic [7:0]         mem_rdata;

    logic        in_acc;
    logic [18:0] stride_sum;
    logic [2:0]  off;
    logic [6:0]  nb_sum;
    logic [3:0]  nbytes;
    logic [5:0]  pix_shift;
    logic [31:0] mask_top;
    logic [31:0] mask_lo;
    logic [31:0] val_top;
    logic [39:0] acc_sh;
    logic [7:0]  merged;
    logic        layout_bad;

    ppst_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    ppst_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'b0, r_ostatus, r_oopaque, r_opixel};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp    <= 6'd8;
            r_width  <= 13'd64;
            r_height <= 13'd64;
        end else if (i_cfg_we) begin
            case (ppst_pkg::t_cfg_index'(i_cfg_index))
                ppst_pkg::CFG_BPP:    r_bpp    <= i_cfg_data[5:0];
                ppst_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                ppst_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // multiplier operand select
    always_comb begin
        case (r_state)
            S_IDLE: begin
                mul_a = {3'b0, r_width};
                mul_b = {7'b0, r_bpp};
            end
            S_USED: begin
                mul_a = r_stride;
                mul_b = r_height;
            end
            S_CHECK: begin
                mul_a = {4'b0, r_col};
                mul_b = {7'b0, r_bpp};
            end
            S_PIX1: begin
                mul_a = r_stride;
                mul_b = {1'b0, r_row};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        stride_sum = prod[18:0] + 19'd7;
        layout_bad = (prod > PROD_W'(ppst_pkg::STORE_BYTES));
        off        = r_bitpos[2:0];
        nb_sum     = {4'b0, off} + {1'b0, r_bpp} + 7'd7;
        nbytes     = nb_sum[6:3];
        pix_shift  = {nbytes[2:0], 3'b000} - {3'b0, off} - r_bpp;
        mask_top   = ~(32'hFFFF_FFFF >> r_bpp);
        mask_lo    = ~(32'hFFFF_FFFF << r_bpp);
        val_top    = r_pix << (ppst_pkg::BPP_MAX - r_bpp);
        acc_sh     = r_acc >> r_shift;
        merged     = (mem_rdata & ~r_mask[39:32]) | (r_val[39:32] & r_mask[39:32]);
    end

    // memory port requests
    always_comb begin
        mem_req = '0;
        case (r_state)
            S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_addr;
                mem_req.wdata = 8'h00;
            end
            S_RD, S_FRA, S_ORD: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = r_addr;
            end
            S_RDW: begin
                mem_req.we    = (r_op == ppst_pkg::OP_WRITE);
                mem_req.waddr = r_addr;
                mem_req.wdata = merged;
            end
            S_FRB: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = r_addr_b;
            end
            S_FWA: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_addr;
                mem_req.wdata = mem_rdata;
            end
            S_FWB: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_addr_b;
                mem_req.wdata = r_tmp;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == {ADDR_W{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_op     <= ppst_pkg::t_op'(s_axis_tdata[1:0]);
                        r_row    <= s_axis_tdata[13:2];
                        r_col    <= s_axis_tdata[25:14];
                        r_pix    <= s_axis_tdata[57:26];
                        r_pixel  <= '0;
                        r_opaque <= 1'b0;
                        r_status <= 1'b0;
                        if (r_bpp == 6'd0 || r_bpp > ppst_pkg::BPP_MAX) begin
                            r_status <= 1'b1;
                            r_state  <= S_RES;
                        end else begin
                            r_state <= S_STRIDE;
                        end
                    end
                end
                S_STRIDE: begin
                    r_stride <= stride_sum[18:3];
                    r_state  <= S_USED;
                end
                S_USED: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    // product now holds the used byte count
                    if (layout_bad) begin
                        r_status <= 1'b1;
                        r_state  <= S_RES;
                    end else begin
                        case (r_op)
                            ppst_pkg::OP_READ, ppst_pkg::OP_WRITE: begin
                                if ({1'b0, r_row} >= r_height || {1'b0, r_col} >= r_width) begin
                                    r_status <= 1'b1;
                                    r_state  <= S_RES;
                                end else begin
                                    r_state <= S_PIX1;
                                end
                            end
                            ppst_pkg::OP_FLIP: begin
                                r_addr   <= '0;
                                r_addr_b <= prod[ADDR_W-1:0] - r_stride[ADDR_W-1:0];
                                r_cnt    <= CNT_W'(r_stride);
                                r_pairs  <= r_height[12:1];
                                if (r_stride == 16'd0 || r_height[12:1] == 12'd0) begin
                                    r_state <= S_RES;
                                end else begin
                                    r_state <= S_FRA;
                                end
                            end
                            default: begin
                                r_opaque <= 1'b1;
                                r_addr   <= '0;
                                r_cnt    <= prod[CNT_W-1:0];
                                if (prod[CNT_W-1:0] == '0) begin
                                    r_state <= S_RES;
                                end else begin
                                    r_state <= S_ORD;
                                end
                            end
                        endcase
                    end
                end
                S_PIX1: begin
                    r_bitpos <= prod[17:0];
                    r_state  <= S_PIX2;
                end
                S_PIX2: begin
                    r_addr  <= prod[ADDR_W-1:0] + ADDR_W'(r_bitpos[17:3]);
                    r_cnt   <= CNT_W'(nbytes);
                    r_shift <= pix_shift;
                    r_acc   <= '0;
                    r_mask  <= {mask_top, 8'h00} >> off;
                    r_val   <= {val_top, 8'h00} >> off;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_RDW;
                end
                S_RDW: begin
                    r_acc  <= {r_acc[31:0], mem_rdata};
                    r_mask <= {r_mask[31:0], 8'h00};
                    r_val  <= {r_val[31:0], 8'h00};
                    r_addr <= r_addr + 1'b1;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= (r_op == ppst_pkg::OP_READ) ? S_PIXOUT : S_RES;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_PIXOUT: begin
                    r_pixel <= acc_sh[31:0] & mask_lo;
                    r_state <= S_RES;
                end
                S_FRA: begin
                    r_state <= S_FRB;
                end
                S_FRB: begin
                    r_tmp   <= mem_rdata;
                    r_state <= S_FWA;
                end
                S_FWA: begin
                    r_state <= S_FWB;
                end
                S_FWB: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        // step the bottom pointer back to the start of the row above
                        r_cnt    <= CNT_W'(r_stride);
                        r_addr_b <= r_addr_b + 1'b1 - {r_stride[ADDR_W-2:0], 1'b0};
                        r_pairs  <= r_pairs - 1'b1;
                        r_state  <= (r_pairs == 12'd1) ? S_RES : S_FRA;
                    end else begin
                        r_cnt    <= r_cnt - 1'b1;
                        r_addr_b <= r_addr_b + 1'b1;
                        r_state  <= S_FRA;
                    end
                end
                S_ORD: begin
                    r_state <= S_OCMP;
                end
                S_OCMP: begin
                    r_addr <= r_addr + 1'b1;
                    r_cnt  <= r_cnt - 1'b1;
                    if (mem_rdata != ppst_pkg::BYTE_ALL) begin
                        r_opaque <= 1'b0;
                        r_state  <= S_RES;
                    end else if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_RES;
                    end else begin
                        r_state <= S_ORD;
                    end
                end
                S_RES: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid  <= 1'b1;
                        r_opixel  <= r_pixel;
                        r_oopaque <= r_opaque;
                        r_ostatus <= r_status;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a refused access reports nothing else
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[32:0] == 33'd0)
        else $error("refused transaction carries data");

    // the memory is never written while the block waits for an item
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !mem_req.we)
        else $error("memory write while idle");

    // an accepted item closes the input until its result is built
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input reopened right after accept");

    // the clearing pass writes zeros only
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> mem_req.we && mem_req.wdata == 8'h00)
        else $error("clearing pass wrote nonzero data");

    // a result is only loaded when the output slot is free or being emptied
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("pending result lost");

endmodule
`default_nettype wire
